FILE: sv/squared_exp_kernel_derivatives_unit_assert.svh
// Assertion macros for the squared-exponential kernel unit.
// Used by the top level only; no other dependencies.
`ifndef SQUARED_EXP_KERNEL_DERIVATIVES_UNIT_ASSERT_SVH
`define SQUARED_EXP_KERNEL_DERIVATIVES_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SEK_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("sek assertion failed");
`define SEK_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("sek assertion failed");
`else
`define SEK_ASSERT_ALWAYS(lbl, expr)
`define SEK_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: sv/sek_pkg.sv
// Shared types and constants of the squared-exponential kernel unit.
// No dependencies.
package sek_pkg;
    localparam int DIM           = 4;
    localparam int FRAC_BITS     = 16;
    localparam int EXP_TERMS     = 20;
    localparam int EXP_SQUARINGS = 8;
    localparam int D2_W          = 68;

    localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;
    localparam logic [31:0] THREE_U = 32'h0300_0000;

    localparam int SH_VAL = FRAC_BITS + 32;
    localparam int SH_G0  = 31;
    localparam int SH_G1  = 56;
    localparam int SH_H00 = 31 - FRAC_BITS;
    localparam int SH_H11 = 48 - FRAC_BITS;
    localparam int SH_H01 = 55 - FRAC_BITS;

    localparam logic [2:0] OP_ZERO = 3'd0;
    localparam logic [2:0] OP_VAL  = 3'd1;
    localparam logic [2:0] OP_G0   = 3'd2;
    localparam logic [2:0] OP_G1   = 3'd3;
    localparam logic [2:0] OP_H00  = 3'd4;
    localparam logic [2:0] OP_H11  = 3'd5;
    localparam logic [2:0] OP_H01  = 3'd6;

    localparam logic REG_SIGNAL = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    // Per-item state that travels down the pipeline.
    typedef struct packed {
        logic         vld;
        logic [2:0]   op;
        logic [31:0]  u;
        logic [62:0]  p;
        logic [32:0]  f;
        logic [63:0]  fu;
        logic [127:0] acc;
        logic         neg;
    } side_t;
endpackage

FILE: sv/sek_lane.sv
// One coordinate lane: registered square of the coordinate difference.
// Depends on sek_pkg.
module sek_lane import sek_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] coord_a,
    input  logic signed [31:0] coord_b,
    output logic [65:0]        sq
);
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [65:0]        sq_reg;

    always_comb begin
        diff = 33'(coord_a) - 33'(coord_b);
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= 66'(mag) * 66'(mag);
        end
    end

    assign sq = sq_reg;
endmodule

FILE: sv/sek_merge.sv
// Merging stage: sums the lane squares into the squared distance.
// Depends on sek_pkg.
module sek_merge import sek_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [65:0]      sq [DIM],
    input  side_t            side_in,
    output logic [D2_W-1:0]  d2,
    output side_t            side_out
);
    logic [D2_W-1:0] sum;
    logic [D2_W-1:0] d2_reg;
    side_t           side_reg;

    always_comb begin
        sum = '0;
        for (int k = 0; k < DIM; k++) begin
            sum = sum + D2_W'(sq[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.vld <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
            d2_reg   <= sum;
        end
    end

    assign d2       = d2_reg;
    assign side_out = side_reg;
endmodule

FILE: sv/sek_mul.sv
// Two-stage 64x64 multiplier built from four 32x32 partial products.
// Depends on sek_pkg.
module sek_mul import sek_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    input  side_t         side_in,
    output logic [127:0]  prod,
    output side_t         side_out
);
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod_reg;
    side_t        s1_reg, s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld <= 1'b0;
            s2_reg.vld <= 1'b0;
        end else if (en) begin
            p00_reg  <= 64'(a[31:0])  * 64'(b[31:0]);
            p01_reg  <= 64'(a[31:0])  * 64'(b[63:32]);
            p10_reg  <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg  <= 64'(a[63:32]) * 64'(b[63:32]);
            s1_reg   <= side_in;
            prod_reg <= 128'(p00_reg) + (128'(p01_reg) << 32) + (128'(p10_reg) << 32)
                        + (128'(p11_reg) << 64);
            s2_reg   <= s1_reg;
        end
    end

    assign prod     = prod_reg;
    assign side_out = s2_reg;
endmodule

FILE: sv/sek_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32-bit quotient
// saturated to all ones on overflow. Depends on sek_pkg.
module sek_div import sek_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [95:0]   num,
    input  logic [63:0]   den,
    input  side_t         side_in,
    output logic [31:0]   quo,
    output side_t         side_out
);
    logic [63:0] r_reg   [33];
    logic [31:0] lo_reg  [33];
    logic [31:0] q_reg   [33];
    logic [63:0] den_reg [33];
    logic        ovf_reg [33];
    side_t       side_reg [33];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0].vld <= 1'b0;
        end else if (en) begin
            r_reg[0]    <= num[95:32];
            lo_reg[0]   <= num[31:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= num[95:32] >= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar g = 0; g < 32; g++) begin : g_stage
        logic [64:0] r2;
        logic        ge;
        always_comb begin
            r2 = {r_reg[g], lo_reg[g][31]};
            ge = r2 >= {1'b0, den_reg[g]};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[g+1].vld <= 1'b0;
            end else if (en) begin
                r_reg[g+1]    <= ge ? 64'(r2 - {1'b0, den_reg[g]}) : r2[63:0];
                lo_reg[g+1]   <= {lo_reg[g][30:0], 1'b0};
                q_reg[g+1]    <= {q_reg[g][30:0], ge};
                den_reg[g+1]  <= den_reg[g];
                ovf_reg[g+1]  <= ovf_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign quo      = ovf_reg[32] ? '1 : q_reg[32];
    assign side_out = side_reg[32];
endmodule

FILE: sv/sek_exp.sv
// exp(-u/2): Horner series of exp(-u/512) then repeated squaring, rounded
// into f (Q1.32). Depends on sek_pkg and sek_mul.
module sek_exp import sek_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  side_t  side_in,
    output side_t  side_out
);
    side_t hs [EXP_TERMS + 1];
    side_t qs [EXP_SQUARINGS + 1];
    logic [63:0] fsum;

    assign hs[0] = side_in;

    for (genvar g = 0; g < EXP_TERMS; g++) begin : g_term
        localparam int K  = EXP_TERMS - g;
        localparam int LG = $clog2(K);
        localparam logic [127:0] RECIP_W = ((128'd1 << (63 + LG)) / K) + 128'd1;
        logic [127:0] prod_a, prod_b;
        side_t        side_a, side_b;
        logic [63:0]  q;

        sek_mul u_mul_x (
            .aclk, .aresetn, .en,
            .a({3'b0, hs[g].u, 29'b0}), .b({1'b0, hs[g].p}),
            .side_in(hs[g]), .prod(prod_a), .side_out(side_a)
        );
        // divide by the term index through its reciprocal
        sek_mul u_mul_k (
            .aclk, .aresetn, .en,
            .a(prod_a[125:62]), .b(RECIP_W[63:0]),
            .side_in(side_a), .prod(prod_b), .side_out(side_b)
        );
        always_comb begin
            q       = 64'(prod_b >> (63 + LG));
            hs[g+1] = side_b;
            hs[g+1].p = ONE_Q62 - q[62:0];
        end
    end

    assign qs[0] = hs[EXP_TERMS];

    for (genvar g = 0; g < EXP_SQUARINGS; g++) begin : g_square
        logic [127:0] prod;
        side_t        side_s;
        sek_mul u_mul_sq (
            .aclk, .aresetn, .en,
            .a({1'b0, qs[g].p}), .b({1'b0, qs[g].p}),
            .side_in(qs[g]), .prod(prod), .side_out(side_s)
        );
        always_comb begin
            qs[g+1]   = side_s;
            qs[g+1].p = prod[124:62];
        end
    end

    always_comb begin
        fsum       = 64'(qs[EXP_SQUARINGS].p) + 64'h2000_0000;
        side_out   = qs[EXP_SQUARINGS];
        side_out.f = fsum[62:30];
    end
endmodule

FILE: sv/squared_exp_kernel_derivatives_unit.sv
// Squared-exponential kernel with hyperparameter derivatives, Q16.16.
// One beat per cycle while the output queue has room; the whole pipeline stalls when it is full.
// Depth is set by the two dividers and the exp chain (48 multipliers).
// A two-entry output queue keeps input open while a result waits.
// Synchronous active-low reset empties the pipeline; scales reset to 1.0.
module squared_exp_kernel_derivatives_unit import sek_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [1:0]         s_index_i,
    input  logic [1:0]         s_index_j,
    input  logic signed [31:0] s_first_point_c0,
    input  logic signed [31:0] s_first_point_c1,
    input  logic signed [31:0] s_first_point_c2,
    input  logic signed [31:0] s_first_point_c3,
    input  logic signed [31:0] s_second_point_c0,
    input  logic signed [31:0] s_second_point_c1,
    input  logic signed [31:0] s_second_point_c2,
    input  logic signed [31:0] s_second_point_c3,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_kernel_result,
    output logic               m_saturated
);
`include "squared_exp_kernel_derivatives_unit_assert.svh"

    logic [31:0] s_reg, l_reg;
    logic [63:0] ss_reg, l2_reg;
    logic [31:0] lc;
    logic        en;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LENGTH) ? l_reg : s_reg;
    assign lc     = (l_reg == '0) ? 32'd1 : l_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg  <= 32'h0001_0000;
            l_reg  <= 32'h0001_0000;
            ss_reg <= 64'h1_0000_0000;
            l2_reg <= 64'h1_0000_0000;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_SIGNAL) begin
                    s_reg <= pwdata;
                end else begin
                    l_reg <= pwdata;
                end
            end
            ss_reg <= 64'(s_reg) * 64'(s_reg);
            l2_reg <= 64'(lc) * 64'(lc);
        end
    end

    // input decode
    side_t side0, side1_reg, side2, side3r, side3, side4, side5r, side5;
    side_t side6r, side6, side7, side8;
    logic signed [31:0] pa [4];
    logic signed [31:0] pb [4];
    logic [65:0]        sq [DIM];
    logic [D2_W-1:0]    d2;
    logic [31:0]        q_u, q_r, w;
    logic [127:0]       prod_fu, prod1, prod2;
    logic [63:0]        m1a, m1b;
    logic [95:0]        num_r;
    logic [63:0]        den_r;

    assign pa[0] = s_first_point_c0;
    assign pa[1] = s_first_point_c1;
    assign pa[2] = s_first_point_c2;
    assign pa[3] = s_first_point_c3;
    assign pb[0] = s_second_point_c0;
    assign pb[1] = s_second_point_c1;
    assign pb[2] = s_second_point_c2;
    assign pb[3] = s_second_point_c3;

    always_comb begin
        side0     = '0;
        side0.vld = s_valid;
        unique case (s_mode)
            2'd0: side0.op = OP_VAL;
            2'd1: begin
                if (s_index_i == 2'd0) side0.op = OP_G0;
                else if (s_index_i == 2'd1) side0.op = OP_G1;
                else side0.op = OP_ZERO;
            end
            2'd2: begin
                if (s_index_i == 2'd0 && s_index_j == 2'd0) side0.op = OP_H00;
                else if (s_index_i == 2'd1 && s_index_j == 2'd1) side0.op = OP_H11;
                else if ((s_index_i == 2'd0 && s_index_j == 2'd1) ||
                         (s_index_i == 2'd1 && s_index_j == 2'd0)) side0.op = OP_H01;
                else side0.op = OP_ZERO;
            end
            default: side0.op = OP_ZERO;
        endcase
    end

    for (genvar k = 0; k < DIM; k++) begin : g_lane
        sek_lane u_lane (.aclk, .en, .coord_a(pa[k]), .coord_b(pb[k]), .sq(sq[k]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg.vld <= 1'b0;
        end else if (en) begin
            side1_reg <= side0;
        end
    end

    sek_merge u_merge (
        .aclk, .aresetn, .en, .sq, .side_in(side1_reg), .d2, .side_out(side2)
    );

    // u = d^2 / l^2 in Q8.24
    sek_div u_div_u (
        .aclk, .aresetn, .en,
        .num({4'b0, d2, 24'b0}), .den(l2_reg),
        .side_in(side2), .quo(q_u), .side_out(side3r)
    );

    always_comb begin
        side3     = side3r;
        side3.u   = q_u;
        side3.p   = ONE_Q62;
        side3.neg = (side3r.op == OP_H11) && (q_u < THREE_U);
    end

    sek_exp u_exp (.aclk, .aresetn, .en, .side_in(side3), .side_out(side4));

    sek_mul u_mul_fu (
        .aclk, .aresetn, .en,
        .a({31'b0, side4.f}), .b({32'b0, side4.u}),
        .side_in(side4), .prod(prod_fu), .side_out(side5r)
    );

    always_comb begin
        side5    = side5r;
        side5.fu = prod_fu[63:0];
        w = (side5r.u >= THREE_U) ? (side5r.u - THREE_U) : (THREE_U - side5r.u);
        case (side5r.op)
            OP_VAL:  begin m1a = ss_reg;         m1b = {31'b0, side5r.f}; end
            OP_G0:   begin m1a = {32'b0, s_reg}; m1b = {31'b0, side5r.f}; end
            OP_G1:   begin m1a = ss_reg;         m1b = prod_fu[63:0];     end
            OP_H01:  begin m1a = {32'b0, s_reg}; m1b = prod_fu[63:0];     end
            OP_H00:  begin m1a = {31'b0, side5r.f}; m1b = 64'd1;         end
            OP_H11:  begin m1a = prod_fu[63:0];  m1b = {32'b0, w};        end
            default: begin m1a = '0;             m1b = '0;                end
        endcase
    end

    sek_mul u_mul_1 (
        .aclk, .aresetn, .en, .a(m1a), .b(m1b),
        .side_in(side5), .prod(prod1), .side_out(side6r)
    );

    always_comb begin
        side6     = side6r;
        side6.acc = prod1;
    end

    // second product only matters for the (1,1) Hessian entry
    sek_mul u_mul_2 (
        .aclk, .aresetn, .en, .a(ss_reg), .b(prod1[95:32]),
        .side_in(side6), .prod(prod2), .side_out(side7)
    );

    always_comb begin
        case (side7.op)
            OP_VAL:  begin num_r = 96'(side7.acc >> SH_VAL); den_r = 64'd1;         end
            OP_G0:   begin num_r = 96'(side7.acc >> SH_G0);  den_r = 64'd1;         end
            OP_G1:   begin num_r = 96'(side7.acc >> SH_G1);  den_r = {32'b0, lc};   end
            OP_H00:  begin num_r = 96'(side7.acc >> SH_H00); den_r = 64'd1;         end
            OP_H11:  begin num_r = 96'(prod2 >> SH_H11);     den_r = l2_reg;        end
            OP_H01:  begin num_r = 96'(side7.acc >> SH_H01); den_r = {32'b0, lc};   end
            default: begin num_r = '0;                       den_r = 64'd1;         end
        endcase
    end

    sek_div u_div_r (
        .aclk, .aresetn, .en, .num(num_r), .den(den_r),
        .side_in(side7), .quo(q_r), .side_out(side8)
    );

    // saturate and sign
    logic [31:0] res;
    logic        sat;
    always_comb begin
        if (!side8.neg) begin
            sat = q_r > 32'h7FFF_FFFF;
            res = sat ? 32'h7FFF_FFFF : q_r;
        end else begin
            sat = q_r > 32'h8000_0000;
            res = sat ? 32'h8000_0000 : 32'(-q_r);
        end
    end

    // two-entry output queue
    logic [31:0] oq_res_reg [2];
    logic        oq_sat_reg [2];
    logic [1:0]  count_reg;
    logic        push, pop, push_head;

    assign en        = (count_reg != 2'd2);
    assign s_ready   = en;
    assign push      = en && side8.vld;
    assign pop       = m_valid && m_ready;
    // new beat lands at the head when the queue is empty or the head leaves now
    assign push_head = push && (count_reg == 2'd0 || pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= 2'(count_reg + {1'b0, push} - {1'b0, pop});
            if (push_head) begin
                oq_res_reg[0] <= res;
                oq_sat_reg[0] <= sat;
            end else if (pop) begin
                oq_res_reg[0] <= oq_res_reg[1];
                oq_sat_reg[0] <= oq_sat_reg[1];
            end
            if (push && !push_head) begin
                oq_res_reg[1] <= res;
                oq_sat_reg[1] <= sat;
            end
        end
    end

    assign m_valid         = (count_reg != 2'd0);
    assign m_kernel_result = oq_res_reg[0];
    assign m_saturated     = oq_sat_reg[0];

    `SEK_ASSERT_ALWAYS(a_count_range, count_reg != 2'd3)
    `SEK_ASSERT_ALWAYS(a_sat_extreme, !(m_valid && m_saturated) ||
        (m_kernel_result == 32'sh7FFF_FFFF || m_kernel_result == 32'sh8000_0000))
    `SEK_ASSERT_NEXT(a_drain, count_reg == 2'd1 && pop && !push, !m_valid)
endmodule

FILE: tb/squared_exp_kernel_derivatives_unit_test.sv
// Self-checking bench for the squared-exponential kernel unit: random and directed point pairs.
// Expected results come from a bit-exact fixed-point predictor kept here; needs sek_pkg and the
// unit itself.
module squared_exp_kernel_derivatives_unit_test import sek_pkg::*;;

    localparam int          HOLDOFF_CYCLES = 600;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 200;
    localparam logic [1:0]  MODE_VALUE     = 2'd0;
    localparam logic [1:0]  MODE_GRAD      = 2'd1;
    localparam logic [1:0]  MODE_HESS      = 2'd2;
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;
    localparam logic [1:0]  IDX_SIGNAL     = 2'd0;
    localparam logic [1:0]  IDX_LENGTH     = 2'd1;
    localparam logic [2:0]  ADDR_SIGNAL    = 3'd0;
    localparam logic [2:0]  ADDR_LENGTH    = 3'd4;
    localparam logic [31:0] Q_ONE          = 32'h0001_0000;
    localparam logic [63:0] MASK32         = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]       mode;
        logic [1:0]       idx_i;
        logic [1:0]       idx_j;
        logic [3:0][31:0] pa;
        logic [3:0][31:0] pb;
    } pair_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } kres_t;

    logic aclk, aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [1:0] s_mode, s_index_i, s_index_j;
    logic signed [31:0] s_first_point_c0, s_first_point_c1, s_first_point_c2, s_first_point_c3;
    logic signed [31:0] s_second_point_c0, s_second_point_c1, s_second_point_c2, s_second_point_c3;
    logic m_valid, m_ready;
    logic signed [31:0] m_kernel_result;
    logic m_saturated;

    squared_exp_kernel_derivatives_unit u_dut (.*);

    pair_t pending_pairs[$];
    kres_t kernel_expected[$];
    pair_t pair_on_bus;
    logic [31:0] scale_s, scale_l;
    int send_idle_pct, recv_stall_pct;
    int errors, results_seen, sat_seen, idle_cycles, holdoff_left;
    logic holdoff_arm, holdoff_done;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] den);
        logic [127:0] q;
        if (num[127:64] >= den) return '1;
        q = num / {64'd0, den};
        return q[63:0];
    endfunction

    function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        return pr[125:62];
    endfunction

    // exp(-u/2): Taylor series of exp(-u/512), then square eight times
    function automatic logic [63:0] half_exp(logic [63:0] u);
        logic [63:0] x, p;
        x = u << 29;
        p = 64'd1 << 62;
        for (int k = EXP_TERMS; k >= 1; k--) p = (64'd1 << 62) - q62_mul(x, p) / 64'(k);
        for (int k = 0; k < EXP_SQUARINGS; k++) p = q62_mul(p, p);
        return (p + (64'd1 << 29)) >> 30;
    endfunction

    function automatic kres_t kernel_predict(pair_t it);
        logic [63:0] l, l2, u, f, fu, mag, w, p, m, ss;
        logic [127:0] d2, t;
        logic signed [63:0] dv;
        logic neg;
        kres_t r;
        l = (scale_l == 0) ? 64'd1 : {32'd0, scale_l};
        l2 = l * l;
        ss = {32'd0, scale_s} * {32'd0, scale_s};
        d2 = '0;
        for (int k = 0; k < DIM; k++) begin
            dv = 64'(signed'(it.pa[k])) - 64'(signed'(it.pb[k]));
            m = dv < 0 ? -dv : dv;
            d2 = d2 + {64'd0, m * m};
        end
        u = div_sat(d2 << 24, l2);
        if (u > MASK32) u = MASK32;
        f = half_exp(u);
        fu = f * u;
        mag = '0;
        neg = 1'b0;
        if (it.mode == MODE_VALUE) begin
            mag = div_sat(({64'd0, ss} * {64'd0, f}) >> SH_VAL, 64'd1);
        end else if (it.mode == MODE_GRAD && it.idx_i == IDX_SIGNAL) begin
            mag = ({32'd0, scale_s} * f) >> SH_G0;
        end else if (it.mode == MODE_GRAD && it.idx_i == IDX_LENGTH) begin
            mag = div_sat(({64'd0, ss} * {64'd0, fu}) >> SH_G1, l);
        end else if (it.mode == MODE_HESS && it.idx_i == IDX_SIGNAL && it.idx_j == IDX_SIGNAL) begin
            mag = f >> SH_H00;
        end else if (it.mode == MODE_HESS && it.idx_i == IDX_LENGTH && it.idx_j == IDX_LENGTH) begin
            w = (u >= {32'd0, THREE_U}) ? u - THREE_U : {32'd0, THREE_U} - u;
            t = {64'd0, fu} * {64'd0, w};
            p = t[95:32];
            mag = div_sat(({64'd0, ss} * {64'd0, p}) >> SH_H11, l2);
            neg = u < {32'd0, THREE_U};
        end else if (it.mode == MODE_HESS && ((it.idx_i == IDX_SIGNAL && it.idx_j == IDX_LENGTH) ||
                                            (it.idx_i == IDX_LENGTH && it.idx_j == IDX_SIGNAL))) begin
            mag = div_sat(({96'd0, scale_s} * {64'd0, fu}) >> SH_H01, l);
        end
        r.sat = 1'b0;
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin mag = 64'h7FFF_FFFF; r.sat = 1'b1; end
            r.value = mag[31:0];
        end else begin
            if (mag > 64'h8000_0000) begin mag = 64'h8000_0000; r.sat = 1'b1; end
            r.value = -mag[31:0];
        end
        return r;
    endfunction

    // input driver and prediction at each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) kernel_expected.push_back(kernel_predict(pair_on_bus));
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pair_on_bus = pending_pairs.pop_front();
                    s_mode <= pair_on_bus.mode;
                    s_index_i <= pair_on_bus.idx_i;
                    s_index_j <= pair_on_bus.idx_j;
                    s_first_point_c0 <= pair_on_bus.pa[0];
                    s_first_point_c1 <= pair_on_bus.pa[1];
                    s_first_point_c2 <= pair_on_bus.pa[2];
                    s_first_point_c3 <= pair_on_bus.pa[3];
                    s_second_point_c0 <= pair_on_bus.pb[0];
                    s_second_point_c1 <= pair_on_bus.pb[1];
                    s_second_point_c2 <= pair_on_bus.pb[2];
                    s_second_point_c3 <= pair_on_bus.pb[3];
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with a single long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end else if (holdoff_arm && !holdoff_done) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // result monitor
    always @(posedge aclk) begin : p_monitor
        kres_t e;
        int bad;
        if (aresetn && m_valid && m_ready) begin
            bad = 0;
            results_seen <= results_seen + 1;
            if (kernel_expected.size() == 0) begin
                $error("result beat with nothing expected: %0d", m_kernel_result);
                bad = 1;
            end else begin
                e = kernel_expected.pop_front();
                if (m_saturated) sat_seen <= sat_seen + 1;
                if (m_kernel_result !== e.value) begin
                    $error("kernel_result expected %0d got %0d", $signed(e.value), m_kernel_result);
                    bad = bad + 1;
                end
                if (m_saturated !== e.sat) begin
                    $error("saturated expected %0d got %0d", e.sat, m_saturated);
                    bad = bad + 1;
                end
            end
            if (bad != 0) errors <= errors + bad;
        end
    end

    // watchdog on cycles with no beat while work is outstanding
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (pending_pairs.size() == 0 && kernel_expected.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d results outstanding", kernel_expected.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SIGNAL) scale_s = data;
        else if (addr == ADDR_LENGTH) scale_l = data;
    endtask

    task automatic add_pair(input logic [1:0] md, input logic [1:0] ii, input logic [1:0] jj,
                            input logic [3:0][31:0] a, input logic [3:0][31:0] b);
        pair_t it;
        it.mode = md;
        it.idx_i = ii;
        it.idx_j = jj;
        it.pa = a;
        it.pb = b;
        pending_pairs.push_back(it);
    endtask

    // mostly nearby points scaled to the length, some fully random
    task automatic add_random_pairs(input int count);
        pair_t it;
        int lg, sh;
        logic [31:0] d;
        for (int n = 0; n < count; n++) begin
            it.mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
            it.idx_i = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
            it.idx_j = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
            lg = 0;
            for (int b = 0; b < 32; b++) if (scale_l[b]) lg = b + 1;
            for (int k = 0; k < 4; k++) begin
                it.pa[k] = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    it.pb[k] = $urandom;
                end else begin
                    sh = lg + $urandom_range(0, 4) - 3;
                    if (sh < 0) sh = 0;
                    if (sh > 32) sh = 32;
                    d = (sh == 32) ? $urandom : ($urandom & ((32'd1 << sh) - 1));
                    it.pb[k] = $urandom_range(0, 1) ? it.pa[k] + d : it.pa[k] - d;
                end
            end
            pending_pairs.push_back(it);
        end
    endtask

    task automatic wait_drained;
        while (pending_pairs.size() > 0 || s_valid || kernel_expected.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    localparam logic [3:0][31:0] PT_ZERO = '0;
    localparam logic [3:0][31:0] PT_MAX  = {4{32'h7FFF_FFFF}};
    localparam logic [3:0][31:0] PT_MIN  = {4{32'h8000_0000}};
    localparam logic [3:0][31:0] PT_U3   = {32'd0, Q_ONE, Q_ONE, Q_ONE};
    localparam logic [3:0][31:0] PT_HALF = {32'd0, 32'd0, 32'd0, 32'h0000_8000};
    localparam logic [3:0][31:0] PT_NEAR = {32'd0, 32'd0, 32'h0000_F000, 32'h0001_8000};

    logic [31:0] cfg_s[8] = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0002_0000,
                             32'h0001_8000, 32'h0001_0000, 32'd40000, 32'h7FFF_0000};
    logic [31:0] cfg_l[8] = '{32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                             32'h0000_0001, 32'h0000_8000, 32'd300000, 32'h0001_0000};

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_mode = '0; s_index_i = '0; s_index_j = '0;
        {s_first_point_c0, s_first_point_c1, s_first_point_c2, s_first_point_c3} = '0;
        {s_second_point_c0, s_second_point_c1, s_second_point_c2, s_second_point_c3} = '0;
        scale_s = 32'h0001_0000;
        scale_l = 32'h0001_0000;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0; results_seen = 0; sat_seen = 0;
        holdoff_arm = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < 8; ph++) begin
            reg_write(ADDR_SIGNAL, cfg_s[ph]);
            reg_write(ADDR_LENGTH, cfg_l[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (ph == 0) begin
                // every mode and index pair at zero distance, then extremes
                for (int md = 0; md < 4; md++)
                    for (int ii = 0; ii < 2; ii++)
                        for (int jj = 0; jj < 2; jj++)
                            if (md == MODE_HESS || jj == 0)
                                add_pair(2'(md), 2'(ii), 2'(jj), PT_ZERO, PT_ZERO);
                add_pair(MODE_VALUE, IDX_SIGNAL, IDX_SIGNAL, PT_MAX, PT_MIN);
                add_pair(MODE_GRAD, IDX_LENGTH, IDX_SIGNAL, PT_MIN, PT_MAX);
                add_pair(MODE_HESS, IDX_LENGTH, IDX_LENGTH, PT_U3, PT_ZERO);
                add_pair(MODE_HESS, IDX_LENGTH, IDX_LENGTH, PT_HALF, PT_ZERO);
                add_pair(MODE_HESS, IDX_LENGTH, IDX_LENGTH, PT_NEAR, PT_U3);
                add_pair(MODE_HESS, IDX_SIGNAL, IDX_LENGTH, PT_NEAR, PT_ZERO);
                add_pair(MODE_GRAD, 2'd2, IDX_SIGNAL, PT_NEAR, PT_ZERO);
                add_pair(MODE_GRAD, 2'd3, IDX_SIGNAL, PT_NEAR, PT_ZERO);
                add_pair(MODE_HESS, 2'd2, 2'd3, PT_NEAR, PT_ZERO);
                add_pair(MODE_HESS, IDX_LENGTH, 2'd3, PT_NEAR, PT_ZERO);
                add_pair(MODE_UNUSED, 2'd3, 2'd3, PT_MAX, PT_MIN);
            end
            if (ph == 2) holdoff_arm = 1'b1;
            add_random_pairs(175);
            wait_drained();
        end

        $display("covered %0d results (%0d saturated) over 8 scale settings and 4 idle patterns",
                 results_seen, sat_seen);
        $display("scale extremes 0, 1 and full range, with one long output hold-off");
        if (errors == 0 && kernel_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: squared_exp_kernel_derivatives_unit.f
+incdir+sv
sv/sek_pkg.sv
sv/sek_lane.sv
sv/sek_merge.sv
sv/sek_mul.sv
sv/sek_div.sv
sv/sek_exp.sv
sv/squared_exp_kernel_derivatives_unit.sv
tb/squared_exp_kernel_derivatives_unit_test.sv
